// File: sv/bpa_pkg.sv
// Shared types and codes of the buddy page allocator.
package bpa_pkg;

	localparam int unsigned OW = 4;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOSPACE = 2'd1,
		ST_BADFREE = 2'd2
	} status_t;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef struct packed {
		logic          head;
		logic          busy;
		logic [OW-1:0] ord;
	} ent_t;

	typedef struct packed {
		logic clr_step;
		logic load;
		logic scan_rd;
		logic scan_ev;
		logic split_step;
		logic chk_rd;
		logic chk_ev;
		logic bud_rd;
		logic merge_hi;
		logic merge_lo;
		logic st_nospace;
		logic st_badfree;
		logic push;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic is_free;
		logic want_bad;
		logic scan_stop;
		logic found;
		logic split_done;
		logic pg_bad;
		logic chk_ok;
		logic at_top;
		logic bud_out;
		logic bud_ok;
		logic out_free;
	} sts_t;

endpackage

// File: sv/buddy_page_allocator.sv
// Top level of the buddy page allocator: sequencer plus datapath.
//
//  channel  handshake             payload
//  request  in_valid / in_ready   operation, order, page_index
//  result   out_valid / out_ready status, block_page
//
// Allocate walks the block table head to head, reading and then evaluating
// each block, stops early at the first free block of exactly the requested
// order, then halves that block until it fits. Free checks the block, then
// merges it with free buddies. The table has a read port and a write port.
// After reset a clearing pass over every page fills the table; no request
// is taken until it ends. A waiting result stalls only the finish of the next
// request, not its acceptance.
module buddy_page_allocator #(
	parameter int unsigned NUM_PAGES    = 1024,
	parameter int unsigned ORDER_LEVELS = 10,
	parameter int unsigned PW           = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   operation,
	input  logic [bpa_pkg::OW-1:0] order,
	input  logic [PW-1:0]          page_index,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [1:0]             status,
	output logic [PW-1:0]          block_page
);

	bpa_pkg::cmd_t cmd;
	bpa_pkg::sts_t sts;

	// Sequence each request through scan, split, check and merge steps
	bpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Hold the block table and the working registers
	bpa_dp #(
		.NUM_PAGES    (NUM_PAGES),
		.ORDER_LEVELS (ORDER_LEVELS),
		.PW           (PW)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.operation  (operation),
		.order      (order),
		.page_index (page_index),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.block_page (block_page)
	);

	// One request at a time: acceptance drops ready for the next cycle
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while another is in flight");

	// No status code beyond the three defined
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("undefined status code");

	// A page is reported only with a granted allocation
	a_page_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != bpa_pkg::ST_OK |-> block_page == '0)
		else $error("page reported on a failed request");

endmodule

// File: sv/bpa_ctrl.sv
// Sequencer of the buddy page allocator.
module bpa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  bpa_pkg::sts_t sts,
	output bpa_pkg::cmd_t cmd
);

	typedef enum logic [10:0] {
		S_CLEAR   = 11'b00000000001,
		S_IDLE    = 11'b00000000010,
		S_SCAN_RD = 11'b00000000100,
		S_SCAN_EV = 11'b00000001000,
		S_SPLIT   = 11'b00000010000,
		S_FCHK_RD = 11'b00000100000,
		S_FCHK_EV = 11'b00001000000,
		S_MCHK    = 11'b00010000000,
		S_BUD_EV  = 11'b00100000000,
		S_MRG_LO  = 11'b01000000000,
		S_RESP    = 11'b10000000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_FCHK_RD;
					if (sts.is_free == bpa_pkg::OP_ALLOC) state_d = S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				if (sts.want_bad) begin
					cmd.st_nospace = 1'b1;
					state_d        = S_RESP;
				end else begin
					cmd.scan_rd = 1'b1;
					state_d     = S_SCAN_EV;
				end
			end
			S_SCAN_EV: begin
				cmd.scan_ev = 1'b1;
				if (sts.scan_stop) begin
					if (sts.found) begin
						state_d = S_SPLIT;
					end else begin
						cmd.st_nospace = 1'b1;
						state_d        = S_RESP;
					end
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_SPLIT: begin
				cmd.split_step = 1'b1;
				if (sts.split_done) state_d = S_RESP;
			end
			S_FCHK_RD: begin
				if (sts.pg_bad) begin
					cmd.st_badfree = 1'b1;
					state_d        = S_RESP;
				end else begin
					cmd.chk_rd = 1'b1;
					state_d    = S_FCHK_EV;
				end
			end
			S_FCHK_EV: begin
				cmd.chk_ev = 1'b1;
				if (sts.chk_ok) begin
					state_d = S_MCHK;
				end else begin
					cmd.st_badfree = 1'b1;
					state_d        = S_RESP;
				end
			end
			S_MCHK: begin
				if (sts.at_top || sts.bud_out) begin
					state_d = S_RESP;
				end else begin
					cmd.bud_rd = 1'b1;
					state_d    = S_BUD_EV;
				end
			end
			S_BUD_EV: begin
				cmd.merge_hi = 1'b1;
				state_d      = sts.bud_ok ? S_MRG_LO : S_RESP;
			end
			S_MRG_LO: begin
				cmd.merge_lo = 1'b1;
				state_d      = S_MCHK;
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

endmodule

// File: sv/bpa_dp.sv
// Datapath of the buddy page allocator: block table, scan and merge registers, result.
module bpa_dp #(
	parameter int unsigned NUM_PAGES    = 1024,
	parameter int unsigned ORDER_LEVELS = 10,
	parameter int unsigned PW           = 10
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  bpa_pkg::cmd_t            cmd,
	output bpa_pkg::sts_t            sts,
	input  logic                     operation,
	input  logic [bpa_pkg::OW-1:0]   order,
	input  logic [PW-1:0]            page_index,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [1:0]               status,
	output logic [PW-1:0]            block_page
);

	localparam int unsigned WW        = (PW > ORDER_LEVELS) ? PW + 1 : ORDER_LEVELS + 1;
	localparam int unsigned OW        = bpa_pkg::OW;
	localparam int unsigned TOP_PAGES = 1 << (ORDER_LEVELS - 1);
	localparam int unsigned TOP_BASE  = (NUM_PAGES / TOP_PAGES) * TOP_PAGES;
	localparam logic [WW-1:0] NP_W    = WW'(NUM_PAGES);
	localparam logic [WW-1:0] TB_W    = WW'(TOP_BASE);
	localparam logic [WW-1:0] TM_W    = WW'(TOP_PAGES - 1);
	localparam logic [OW-1:0] TOP_ORD = OW'(ORDER_LEVELS - 1);
	localparam logic [WW-1:0] ONE_W   = WW'(1);

	bpa_pkg::ent_t mem [NUM_PAGES];
	bpa_pkg::ent_t rd_q;

	logic [OW-1:0]       want_q, ord_q, best_ord_q, j_q;
	logic [WW-1:0]       pg_q, scan_q, cur_q, bud_q, clr_q;
	logic                found_q;
	bpa_pkg::status_t    st_q;
	logic [PW-1:0]       blk_q;
	logic                out_valid_q;
	bpa_pkg::status_t    status_q;
	logic [PW-1:0]       block_page_q;

	// Scan, check and merge evaluation
	logic          cand, better, found_nxt;
	logic [OW-1:0] best_ord_nxt;
	logic [WW-1:0] best_nxt, scan_nxt, bud, lo, hi;
	logic          chk_ok, bud_ok;

	assign cand         = rd_q.head && !rd_q.busy && (rd_q.ord >= want_q);
	assign better       = cand && (!found_q || (rd_q.ord < best_ord_q));
	assign found_nxt    = found_q || cand;
	assign best_ord_nxt = better ? rd_q.ord : best_ord_q;
	assign best_nxt     = better ? scan_q : cur_q;
	assign scan_nxt     = scan_q + (ONE_W << rd_q.ord);
	assign bud          = pg_q ^ (ONE_W << ord_q);
	assign lo           = (pg_q < bud_q) ? pg_q : bud_q;
	assign hi           = (pg_q < bud_q) ? bud_q : pg_q;
	assign chk_ok       = rd_q.head && rd_q.busy && (rd_q.ord == ord_q);
	assign bud_ok       = rd_q.head && !rd_q.busy && (rd_q.ord == ord_q);

	always_comb begin
		sts            = '0;
		sts.clr_done   = (clr_q == NP_W - ONE_W);
		sts.is_free    = operation;
		sts.want_bad   = (want_q > TOP_ORD);
		sts.scan_stop  = (scan_nxt >= NP_W) || (found_nxt && (best_ord_nxt == want_q));
		sts.found      = found_nxt;
		sts.split_done = (j_q == want_q);
		sts.pg_bad     = (pg_q >= NP_W);
		sts.chk_ok     = chk_ok;
		sts.at_top     = (ord_q >= TOP_ORD);
		sts.bud_out    = (bud >= NP_W);
		sts.bud_ok     = bud_ok;
		sts.out_free   = !out_valid_q || out_ready;
	end

	// Table write and read ports
	logic          wr_en;
	logic [WW-1:0] wr_addr, rd_addr;
	bpa_pkg::ent_t wr_data, init_ent;

	always_comb begin
		init_ent      = '0;
		init_ent.head = (clr_q >= TB_W) || ((clr_q & TM_W) == '0);
		init_ent.ord  = (clr_q < TB_W && init_ent.head) ? TOP_ORD : '0;
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cur_q;
		wr_data = '0;
		if (cmd.clr_step) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = init_ent;
		end else if (cmd.split_step) begin
			wr_en   = 1'b1;
			wr_addr = cur_q;
			wr_data = sts.split_done ? '{head: 1'b1, busy: 1'b1, ord: want_q}
			                         : '{head: 1'b1, busy: 1'b0, ord: j_q - 1'b1};
		end else if (cmd.chk_ev && chk_ok) begin
			wr_en   = 1'b1;
			wr_addr = pg_q;
			wr_data = '{head: 1'b1, busy: 1'b0, ord: ord_q};
		end else if (cmd.merge_hi && bud_ok) begin
			wr_en   = 1'b1;
			wr_addr = hi;
			wr_data = '0;
		end else if (cmd.merge_lo) begin
			// the merged block starts at the lower of the two buddies
			wr_en   = 1'b1;
			wr_addr = lo;
			wr_data = '{head: 1'b1, busy: 1'b0, ord: ord_q + 1'b1};
		end
	end

	always_comb begin
		rd_addr = scan_q;
		if (cmd.chk_rd) rd_addr = pg_q;
		else if (cmd.bud_rd) rd_addr = bud;
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr[PW-1:0]] <= wr_data;
		rd_q <= mem[rd_addr[PW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_step && !sts.clr_done) clr_q <= clr_q + ONE_W;
			if (cmd.push) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			want_q  <= order;
			ord_q   <= order;
			pg_q    <= WW'(page_index);
			scan_q  <= '0;
			found_q <= 1'b0;
			st_q    <= bpa_pkg::ST_OK;
			blk_q   <= '0;
		end
		if (cmd.scan_ev) begin
			scan_q     <= scan_nxt;
			found_q    <= found_nxt;
			best_ord_q <= best_ord_nxt;
			cur_q      <= best_nxt;
			j_q        <= best_ord_nxt;
		end
		if (cmd.split_step) begin
			if (sts.split_done) begin
				blk_q <= cur_q[PW-1:0];
			end else begin
				cur_q <= cur_q + (ONE_W << (j_q - 1'b1));
				j_q   <= j_q - 1'b1;
			end
		end
		if (cmd.bud_rd) bud_q <= bud;
		if (cmd.merge_lo) begin
			pg_q  <= lo;
			ord_q <= ord_q + 1'b1;
		end
		if (cmd.st_nospace) st_q <= bpa_pkg::ST_NOSPACE;
		if (cmd.st_badfree) st_q <= bpa_pkg::ST_BADFREE;
		if (cmd.push) begin
			status_q     <= st_q;
			block_page_q <= blk_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign block_page = block_page_q;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the buddy page allocator.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned PAGES    = 1024;
	localparam int unsigned LEVELS   = 10;
	localparam int unsigned TOP      = LEVELS - 1;
	localparam int unsigned RAND_REQ = 500;
	localparam longint      LIMIT    = 4000000;

	typedef struct {
		logic             op;
		logic [3:0]       ord;
		logic [9:0]       pg;
		bit               typed;     // expected result written in the row
		bpa_pkg::status_t st;
		logic [9:0]       bp;
	} row_t;

	typedef struct {
		bpa_pkg::status_t st;
		logic [9:0]       bp;
	} reply_t;

	typedef struct {
		logic [9:0] pg;
		logic [3:0] ord;
	} live_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic       operation;
	logic [3:0] order;
	logic [9:0] page_index;
	logic       out_valid;
	logic       out_ready;
	logic [1:0] status;
	logic [9:0] block_page;

	// Shadow of the block table
	bit         tbl_head[PAGES];
	bit         tbl_busy[PAGES];
	int         tbl_ord[PAGES];
	live_t      live_blocks[$];
	reply_t     pending_replies[$];

	int         mismatches;
	int         accepted;
	longint     cycles;

	buddy_page_allocator #(
		.NUM_PAGES(PAGES),
		.ORDER_LEVELS(LEVELS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.order(order),
		.page_index(page_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.block_page(block_page)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Reset state: top-order blocks only, every page free
	task automatic table_reset();
		for (int i = 0; i < PAGES; i++) begin
			tbl_busy[i] = 0;
			tbl_head[i] = (i % (1 << TOP)) == 0;
			tbl_ord[i]  = tbl_head[i] ? TOP : 0;
		end
		live_blocks.delete();
	endtask

	// Apply one request to the shadow table and return its result
	task automatic buddy_apply(input logic op, input logic [3:0] ord, input logic [9:0] pg,
			output reply_t r);
		int  best;
		int  best_o;
		int  cur;
		int  o;
		int  p;
		int  bud;
		bit  found;
		r.st = bpa_pkg::ST_OK;
		r.bp = '0;
		if (op == bpa_pkg::OP_ALLOC) begin
			found  = 0;
			best   = 0;
			best_o = 0;
			if (ord > TOP) begin
				r.st = bpa_pkg::ST_NOSPACE;
				return;
			end
			// smallest free block that fits, lowest address first
			for (int i = 0; i < PAGES; i++) begin
				if (tbl_head[i] && !tbl_busy[i] && tbl_ord[i] >= ord &&
						(!found || tbl_ord[i] < best_o)) begin
					found  = 1;
					best   = i;
					best_o = tbl_ord[i];
				end
			end
			if (!found) begin
				r.st = bpa_pkg::ST_NOSPACE;
				return;
			end
			// split: free each lower half, keep walking up
			cur = best;
			for (int j = best_o; j > ord; j--) begin
				tbl_head[cur] = 1;
				tbl_ord[cur]  = j - 1;
				tbl_busy[cur] = 0;
				cur += 1 << (j - 1);
			end
			tbl_head[cur] = 1;
			tbl_ord[cur]  = ord;
			tbl_busy[cur] = 1;
			r.bp = cur[9:0];
			live_blocks.push_back('{cur[9:0], ord});
		end else begin
			p = pg;
			o = ord;
			if (!tbl_head[p] || !tbl_busy[p] || tbl_ord[p] != o || o > TOP) begin
				r.st = bpa_pkg::ST_BADFREE;
				return;
			end
			tbl_busy[p] = 0;
			foreach (live_blocks[k])
				if (live_blocks[k].pg == pg) begin
					live_blocks.delete(k);
					break;
				end
			// merge with the aligned buddy while it is a free block of the same order
			while (o < TOP) begin
				bud = p ^ (1 << o);
				if (bud >= PAGES || !tbl_head[bud] || tbl_busy[bud] || tbl_ord[bud] != o)
					break;
				if (bud < p) begin
					tbl_head[p] = 0;
					tbl_ord[p]  = 0;
					tbl_busy[p] = 0;
					p = bud;
				end else begin
					tbl_head[bud] = 0;
					tbl_ord[bud]  = 0;
					tbl_busy[bud] = 0;
				end
				o++;
				tbl_ord[p] = o;
			end
		end
	endtask

	// Offer one request and hold it until the block takes it
	task automatic send_request(input logic op, input logic [3:0] ord, input logic [9:0] pg,
			output reply_t r);
		in_valid   <= 1'b1;
		operation  <= op;
		order      <= ord;
		page_index <= pg;
		do
			@(posedge clk);
		while (!in_ready);
		buddy_apply(op, ord, pg, r);
		pending_replies.push_back(r);
		accepted++;
	endtask

	task automatic drop_valid(input int gap);
		in_valid <= 1'b0;
		repeat (gap) @(posedge clk);
	endtask

	// Check every result against the oldest pending one
	always @(posedge clk) begin
		reply_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result status=%0d block_page=%0d", status, block_page);
			end else begin
				want = pending_replies.pop_front();
				if (status !== want.st || block_page !== want.bp) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected status=%0d block_page=%0d, got %0d %0d",
							want.st, want.bp, status, block_page);
				end
			end
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Receiver: random stalls, quiet stretches, and one long hold-off
	initial begin
		int  hold;
		bit  held_once;
		held_once = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (!held_once && accepted >= 120) begin
				// hold off long enough for the block to back up into its input
				held_once = 1;
				out_ready <= 1'b0;
				hold = 0;
				while (hold < 3000) begin
					@(posedge clk);
					hold++;
				end
			end else if ((cycles / 500) % 4 == 3) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= $urandom_range(3) != 0;
			end
		end
	end

	// Stimulus
	initial begin
		row_t   rows[$];
		reply_t r;
		int     burst;
		int     pick;
		int     sel;
		logic [3:0] ord;
		mismatches = 0;
		accepted   = 0;
		cycles     = 0;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		operation  = bpa_pkg::OP_ALLOC;
		order      = '0;
		page_index = '0;
		table_reset();

		// op, order, page, typed, status, block_page
		rows = '{
			'{bpa_pkg::OP_ALLOC, 4'd0,  10'd0,    1, bpa_pkg::ST_OK,      10'd511},
			'{bpa_pkg::OP_ALLOC, 4'd9,  10'd0,    1, bpa_pkg::ST_OK,      10'd512},
			'{bpa_pkg::OP_ALLOC, 4'd9,  10'd0,    1, bpa_pkg::ST_NOSPACE, 10'd0},
			'{bpa_pkg::OP_ALLOC, 4'd10, 10'd0,    1, bpa_pkg::ST_NOSPACE, 10'd0},
			'{bpa_pkg::OP_ALLOC, 4'd15, 10'd0,    1, bpa_pkg::ST_NOSPACE, 10'd0},
			'{bpa_pkg::OP_FREE,  4'd0,  10'd1023, 1, bpa_pkg::ST_BADFREE, 10'd0},
			'{bpa_pkg::OP_FREE,  4'd8,  10'd512,  1, bpa_pkg::ST_BADFREE, 10'd0},
			'{bpa_pkg::OP_FREE,  4'd15, 10'd512,  1, bpa_pkg::ST_BADFREE, 10'd0},
			'{bpa_pkg::OP_FREE,  4'd9,  10'd512,  1, bpa_pkg::ST_OK,      10'd0},
			'{bpa_pkg::OP_FREE,  4'd9,  10'd512,  1, bpa_pkg::ST_BADFREE, 10'd0},
			'{bpa_pkg::OP_FREE,  4'd0,  10'd511,  1, bpa_pkg::ST_OK,      10'd0},
			'{bpa_pkg::OP_ALLOC, 4'd9,  10'd1023, 1, bpa_pkg::ST_OK,      10'd0},
			'{bpa_pkg::OP_ALLOC, 4'd9,  10'd0,    1, bpa_pkg::ST_OK,      10'd512},
			'{bpa_pkg::OP_FREE,  4'd9,  10'd0,    1, bpa_pkg::ST_OK,      10'd0},
			'{bpa_pkg::OP_FREE,  4'd9,  10'd512,  1, bpa_pkg::ST_OK,      10'd0},
			'{bpa_pkg::OP_ALLOC, 4'd3,  10'd0,    1, bpa_pkg::ST_OK,      10'd504},
			'{bpa_pkg::OP_ALLOC, 4'd3,  10'd0,    0, bpa_pkg::ST_OK,      10'd0},
			'{bpa_pkg::OP_ALLOC, 4'd1,  10'd0,    0, bpa_pkg::ST_OK,      10'd0},
			'{bpa_pkg::OP_FREE,  4'd3,  10'd504,  0, bpa_pkg::ST_OK,      10'd0},
			'{bpa_pkg::OP_FREE,  4'd3,  10'd503,  0, bpa_pkg::ST_OK,      10'd0},
			'{bpa_pkg::OP_ALLOC, 4'd8,  10'd0,    0, bpa_pkg::ST_OK,      10'd0},
			'{bpa_pkg::OP_ALLOC, 4'd0,  10'd0,    0, bpa_pkg::ST_OK,      10'd0}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (rows[i]) begin
			send_request(rows[i].op, rows[i].ord, rows[i].pg, r);
			if (rows[i].typed && (r.st != rows[i].st || r.bp != rows[i].bp)) begin
				mismatches++;
				if (mismatches <= 10)
					$display("row %0d: model gives %0d %0d, table says %0d %0d",
						i, r.st, r.bp, rows[i].st, rows[i].bp);
			end
			if ($urandom_range(2) == 0)
				drop_valid($urandom_range(1, 6));
		end

		// pause until the directed part has drained
		in_valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);

		// Random part: mostly matched alloc/free, some noise
		burst = $urandom_range(1, 30);
		for (int n = 0; n < RAND_REQ; n++) begin
			sel = $urandom_range(99);
			if (sel < 45 || (sel < 85 && live_blocks.size() == 0)) begin
				pick = $urandom_range(99);
				ord  = (pick < 70) ? 4'($urandom_range(0, 3)) :
					(pick < 95) ? 4'($urandom_range(4, 9)) : 4'($urandom_range(10, 15));
				send_request(bpa_pkg::OP_ALLOC, ord, 10'($urandom), r);
			end else if (sel < 85) begin
				pick = $urandom_range(live_blocks.size() - 1);
				send_request(bpa_pkg::OP_FREE, live_blocks[pick].ord, live_blocks[pick].pg, r);
			end else begin
				send_request(bpa_pkg::OP_FREE, 4'($urandom), 10'($urandom), r);
			end
			burst--;
			if (burst == 0) begin
				burst = $urandom_range(1, 30);
				if ($urandom_range(3) != 0)
					drop_valid($urandom_range(1, 40));
			end
		end

		in_valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: files.f
sv/bpa_pkg.sv
sv/bpa_ctrl.sv
sv/bpa_dp.sv
sv/buddy_page_allocator.sv
tb/testbench.sv
